// ===== src/rau_pkg.sv =====
// package for the rational arithmetic unit: operation and status codes,
// controller/datapath command and status structs. no dependencies.
package rau_pkg;

    localparam int OPERAND_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic prod;      // register products
        logic comb;      // form num/den
        logic norm;      // sign handling, set up gcd
        logic gcd_step;  // one binary gcd step
        logic div_init;  // start exact division
        logic div_step;  // one restoring division bit
        logic fin;       // build result
    } rau_cmd_t;

    // status back to controller
    typedef struct packed {
        logic divz;      // divide by zero fraction
        logic trivial;   // result needs no reduction
        logic gcd_done;
        logic div_done;
    } rau_sts_t;

endpackage

// ===== src/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit with gcd reduction.
// Input channel s_axis: tuser carries the operation (0 add, 1 sub,
// 2 mul, 3 div), tdata the four operands. Output channel m_axis: tdata
// holds reduced numerator and denominator, tuser the status code.
// One item at a time: s_tready is high only while the unit is idle.
// From acceptance to m_tvalid: a divide by zero goes from the product
// state straight to the final state; a zero numerator or zero denominator
// skips the gcd and the divisions; otherwise the binary gcd runs, then
// two restoring divisions by the gcd, which share one subtractor.
// The result is held on m_axis until m_tready; the next item is taken
// only after the result is delivered.
// Reset (aresetn low, synchronous) returns the controller to idle and
// drops m_tvalid; no memory needs clearing.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
module rational_arithmetic_unit_top import rau_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den (32 each)
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // res_num (64), res_den (63), pad
    output logic [1:0]   m_tuser    // status
);

    rau_cmd_t    cmd;
    rau_sts_t    sts;
    logic [63:0] res_num;
    logic [62:0] res_den;

    // controller
    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    // datapath
    rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .aclk(aclk), .cmd(cmd), .sts(sts),
        .action(s_tuser),
        .a_num(s_tdata[OPERAND_BITS-1:0]),
        .a_den(s_tdata[32 +: OPERAND_BITS]),
        .b_num(s_tdata[64 +: OPERAND_BITS]),
        .b_den(s_tdata[96 +: OPERAND_BITS]),
        .res_num(res_num), .res_den(res_den), .status(m_tuser)
    );

    assign m_tdata = {1'b0, res_den, res_num};

`ifndef SYNTHESIS
    // no new item while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    // result stays stable while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("result changed under stall");
    // status is never the unused code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_OVF)) else $error("bad status");
`endif

endmodule

// ===== src/rau_datapath.sv =====
// datapath: operand products, saturating sum, binary gcd and two
// shared-loop exact divisions. depends on rau_pkg.
module rau_datapath import rau_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                    aclk,
    input  rau_cmd_t                cmd,
    output rau_sts_t                sts,
    input  logic [1:0]              action,
    input  logic [OPERAND_BITS-1:0] a_num,
    input  logic [OPERAND_BITS-1:0] a_den,
    input  logic [OPERAND_BITS-1:0] b_num,
    input  logic [OPERAND_BITS-1:0] b_den,
    output logic [63:0]             res_num,
    output logic [62:0]             res_den,
    output logic [1:0]              status
);

    logic [1:0]         act_reg;
    logic signed [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [63:0] p0_reg, p1_reg, den_reg, num_reg;
    logic               ovf_reg, neg_reg, trv_reg;
    logic [63:0]        m_reg, d_reg;              // saved magnitudes
    logic [63:0]        gx_reg, gy_reg;            // gcd working values
    logic [5:0]         gk_reg;                    // common power of two
    logic [63:0]        q_reg, r_reg, dv_reg;      // division
    logic [6:0]         cnt_reg;
    logic               sel_reg;                   // 0 numerator, 1 denominator
    logic [63:0]        qm_reg, qd_reg;

    // sign extension of operands to 32 bits
    function automatic logic signed [31:0] sx(input logic [OPERAND_BITS-1:0] v);
        sx = 32'(signed'(v));
    endfunction

    logic signed [64:0] sum_w;
    logic signed [63:0] sum_sat;
    logic               sum_ovf;
    always_comb begin
        if (act_reg == OP_SUB) sum_w = 65'(p0_reg) - 65'(p1_reg);
        else                   sum_w = 65'(p0_reg) + 65'(p1_reg);
        sum_ovf = sum_w[64] != sum_w[63];
        if (!sum_ovf)         sum_sat = sum_w[63:0];
        else if (sum_w[64])   sum_sat = 64'sh8000_0000_0000_0000;
        else                  sum_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    end

    // normalization view of registered num/den
    logic signed [63:0] n_norm, d_norm;
    logic               ovf_norm;
    always_comb begin
        n_norm = num_reg;
        d_norm = den_reg;
        ovf_norm = ovf_reg;
        if (den_reg < 0) begin
            d_norm = -den_reg;
            if (num_reg == 64'sh8000_0000_0000_0000) begin
                n_norm = 64'sh7FFF_FFFF_FFFF_FFFF;
                ovf_norm = 1'b1;
            end else begin
                n_norm = -num_reg;
            end
        end
    end

    // restoring division step on shared loop
    logic [64:0] rem_try;
    assign rem_try = {r_reg, q_reg[63]} - {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= action;
            an_reg  <= sx(a_num);
            ad_reg  <= sx(a_den);
            bn_reg  <= sx(b_num);
            bd_reg  <= sx(b_den);
        end
        // one 32x32 product per register
        if (cmd.prod) begin
            p0_reg  <= (act_reg == OP_MUL) ? 64'(an_reg) * 64'(bn_reg)
                                           : 64'(an_reg) * 64'(bd_reg);
            p1_reg  <= 64'(bn_reg) * 64'(ad_reg);
            den_reg <= (act_reg == OP_DIV) ? 64'(ad_reg) * 64'(bn_reg)
                                           : 64'(ad_reg) * 64'(bd_reg);
        end
        if (cmd.comb) begin
            if (act_reg == OP_ADD || act_reg == OP_SUB) begin
                num_reg <= sum_sat;
                ovf_reg <= sum_ovf;
            end else begin
                num_reg <= p0_reg;
                ovf_reg <= 1'b0;
            end
        end
        // sign fix, then gcd setup on magnitudes
        if (cmd.norm) begin
            ovf_reg <= ovf_norm;
            neg_reg <= n_norm[63];
            trv_reg <= (num_reg == 64'sd0) || (den_reg == 64'sd0);
            num_reg <= n_norm;
            den_reg <= d_norm;
            m_reg   <= n_norm[63] ? 64'(-n_norm) : n_norm;
            d_reg   <= d_norm;
            gx_reg  <= n_norm[63] ? 64'(-n_norm) : n_norm;
            gy_reg  <= d_norm;
            gk_reg  <= '0;
        end
        // binary gcd: strip common twos, then subtract
        if (cmd.gcd_step) begin
            if (!gx_reg[0] && !gy_reg[0]) begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 6'd1;
            end else if (!gx_reg[0]) begin
                gx_reg <= gx_reg >> 1;
            end else if (!gy_reg[0]) begin
                gy_reg <= gy_reg >> 1;
            end else if (gx_reg >= gy_reg) begin
                gx_reg <= (gx_reg - gy_reg) >> 1;
            end else begin
                gy_reg <= (gy_reg - gx_reg) >> 1;
            end
        end
        if (cmd.div_init) begin
            dv_reg  <= gy_reg << gk_reg;
            q_reg   <= sel_reg ? d_reg : m_reg;
            r_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!rem_try[64]) begin
                r_reg <= rem_try[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= {r_reg[62:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                if (sel_reg) qd_reg <= rem_try[64] ? {q_reg[62:0], 1'b0}
                                                   : {q_reg[62:0], 1'b1};
                else         qm_reg <= rem_try[64] ? {q_reg[62:0], 1'b0}
                                                   : {q_reg[62:0], 1'b1};
                sel_reg <= ~sel_reg;
            end
        end
        if (cmd.load) sel_reg <= 1'b0;
        // final result
        if (cmd.fin) begin
            if (sts.divz) begin
                res_num <= 64'h7FFF_FFFF_FFFF_FFFF;
                res_den <= 63'd1;
                status  <= ST_DIVZ;
            end else begin
                status <= ovf_reg ? ST_OVF : ST_OK;
                if (num_reg == 64'sd0) begin
                    res_num <= '0;
                    res_den <= 63'd1;
                end else if (den_reg == 64'sd0) begin
                    res_num <= num_reg;
                    res_den <= '0;
                end else begin
                    res_num <= neg_reg ? 64'(-qm_reg) : qm_reg;
                    res_den <= qd_reg[62:0];
                end
            end
        end
    end

    always_comb begin
        sts.divz     = (act_reg == OP_DIV) && (bn_reg == 32'sd0);
        sts.trivial  = trv_reg;
        sts.gcd_done = (gx_reg == 64'd0) || (gy_reg == 64'd0);
        sts.div_done = (cnt_reg == 7'd63);
    end

endmodule

// ===== src/rau_ctrl.sv =====
// controller state machine for the rational arithmetic unit.
// depends on rau_pkg.
module rau_ctrl import rau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rau_cmd_t cmd,
    input  rau_sts_t sts
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PROD = 10'b0000000010,
        S_COMB = 10'b0000000100,
        S_NORM = 10'b0000001000,
        S_GCD  = 10'b0000010000,
        S_FIXG = 10'b0000100000,
        S_DINI = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   half_reg, half_next;   // second division pending

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        half_next  = half_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = in_valid;
                if (in_valid) state_next = S_PROD;
            end
            S_PROD: begin
                cmd.prod = 1'b1;
                state_next = sts.divz ? S_FIN : S_COMB;
            end
            S_COMB: begin
                cmd.comb = 1'b1;
                state_next = S_NORM;
            end
            S_NORM: begin
                cmd.norm = 1'b1;
                state_next = S_GCD;
            end
            S_GCD: begin
                if (sts.trivial) state_next = S_FIN;
                else if (sts.gcd_done) state_next = S_FIXG;
                else cmd.gcd_step = 1'b1;
            end
            S_FIXG: begin
                half_next = 1'b0;
                state_next = S_DINI;
            end
            S_DINI: begin
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    half_next = ~half_reg;
                    state_next = half_reg ? S_FIN : S_DINI;
                end
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

endmodule
